### hw/rtl/ratnorm_pkg.sv
// Shared constants, types and the control-store contents of the fraction reducer.
// Depends on nothing; used by rational_normalize and its checker.

package ratnorm_pkg;

	// Width of a signed input or output value.
	localparam int VALUE_WIDTH = 32;

	// Magnitudes need the full width to hold the magnitude of the most negative value.
	localparam int MAG_WIDTH = VALUE_WIDTH;
	localparam int DEN_WIDTH = VALUE_WIDTH - 1;
	localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);

	// Stream widths, rounded up to whole bytes.
	localparam int IN_TDATA_WIDTH  = ((2 * VALUE_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_WIDTH = ((VALUE_WIDTH + DEN_WIDTH + 7) / 8) * 8;

	// Largest magnitude that fits a signed result.
	localparam logic [MAG_WIDTH-1:0] MAG_MAX = {1'b0, {(MAG_WIDTH-1){1'b1}}};

	// Control store addressing.
	localparam int PC_WIDTH = 4;
	typedef logic [PC_WIDTH-1:0] pc_t;

	// Datapath operations.
	typedef logic [3:0] op_t;
	localparam op_t OP_NOP      = 4'd0;
	localparam op_t OP_LOAD     = 4'd1;
	localparam op_t OP_HALVE_AB = 4'd2;
	localparam op_t OP_HALVE_A  = 4'd3;
	localparam op_t OP_HALVE_B  = 4'd4;
	localparam op_t OP_SUB      = 4'd5;
	localparam op_t OP_SETUP_N  = 4'd6;
	localparam op_t OP_DIV      = 4'd7;
	localparam op_t OP_SETUP_D  = 4'd8;
	localparam op_t OP_OUT_FRAC = 4'd9;
	localparam op_t OP_OUT_ZERO = 4'd10;

	// Jump conditions.
	typedef logic [3:0] cond_t;
	localparam cond_t C_NEVER     = 4'd0;
	localparam cond_t C_ALWAYS    = 4'd1;
	localparam cond_t C_NO_ACCEPT = 4'd2;
	localparam cond_t C_ANY_ZERO  = 4'd3;
	localparam cond_t C_BOTH_EVEN = 4'd4;
	localparam cond_t C_A_EVEN    = 4'd5;
	localparam cond_t C_B_EVEN    = 4'd6;
	localparam cond_t C_A_NE_B    = 4'd7;
	localparam cond_t C_CNT_NZ    = 4'd8;
	localparam cond_t C_OUT_BUSY  = 4'd9;

	// One control word: the operation, the jump condition and the jump target.
	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_word_t;

	// Step addresses that the program jumps to.
	localparam pc_t PC_WAIT     = 4'd0;
	localparam pc_t PC_CHECK    = 4'd1;
	localparam pc_t PC_COMMON   = 4'd2;
	localparam pc_t PC_ODD_A    = 4'd3;
	localparam pc_t PC_ODD_B    = 4'd4;
	localparam pc_t PC_SUB      = 4'd5;
	localparam pc_t PC_SETUP_N  = 4'd6;
	localparam pc_t PC_DIV_N    = 4'd7;
	localparam pc_t PC_SETUP_D  = 4'd8;
	localparam pc_t PC_DIV_D    = 4'd9;
	localparam pc_t PC_OUT_FRAC = 4'd10;
	localparam pc_t PC_DONE     = 4'd11;
	localparam pc_t PC_OUT_ZERO = 4'd12;

	// The program. A step jumps to its target when its condition holds and
	// falls through to the next step otherwise.
	function automatic ctrl_word_t ctrl_rom(input pc_t pc);
		ctrl_word_t w;
		begin
			case (pc)
				PC_WAIT:     w = '{OP_LOAD,     C_NO_ACCEPT, PC_WAIT};
				PC_CHECK:    w = '{OP_NOP,      C_ANY_ZERO,  PC_OUT_ZERO};
				PC_COMMON:   w = '{OP_HALVE_AB, C_BOTH_EVEN, PC_COMMON};
				PC_ODD_A:    w = '{OP_HALVE_A,  C_A_EVEN,    PC_ODD_A};
				PC_ODD_B:    w = '{OP_HALVE_B,  C_B_EVEN,    PC_ODD_B};
				PC_SUB:      w = '{OP_SUB,      C_A_NE_B,    PC_ODD_B};
				PC_SETUP_N:  w = '{OP_SETUP_N,  C_NEVER,     PC_WAIT};
				PC_DIV_N:    w = '{OP_DIV,      C_CNT_NZ,    PC_DIV_N};
				PC_SETUP_D:  w = '{OP_SETUP_D,  C_NEVER,     PC_WAIT};
				PC_DIV_D:    w = '{OP_DIV,      C_CNT_NZ,    PC_DIV_D};
				PC_OUT_FRAC: w = '{OP_OUT_FRAC, C_OUT_BUSY,  PC_OUT_FRAC};
				PC_DONE:     w = '{OP_NOP,      C_ALWAYS,    PC_WAIT};
				PC_OUT_ZERO: w = '{OP_OUT_ZERO, C_OUT_BUSY,  PC_OUT_ZERO};
				default:     w = '{OP_NOP,      C_ALWAYS,    PC_WAIT};
			endcase
			return w;
		end
	endfunction

endpackage

### hw/rtl/rational_normalize.sv
// Fraction reducer top level: a microcoded binary gcd and restoring divider.
// Depends on ratnorm_pkg for widths, control codes and the control store.

// Reduces one signed fraction to lowest terms per transaction. The numerator
// and denominator are divided by the gcd of their magnitudes, the sign moves
// to the numerator, and a zero numerator gives 0/1. A zero denominator gives
// 0/1 with tuser set. The block works on one transaction at a time: it takes
// no new fraction until the last one has left the control program. The
// program runs a binary gcd loop of halving steps and subtraction passes, in
// which each halving drops one bit from one or both magnitudes, and then two
// divisions that give one quotient bit per cycle. Zero inputs skip the gcd
// and the divisions. A finished result waits in the output register while
// the next transaction is accepted.

module rational_normalize (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// numerator_in, denominator_in
	input  logic [ratnorm_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// numerator_out, denominator_out, zero padding
	output logic [ratnorm_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
	// zero_denominator
	output logic                                   m_axis_tuser
);

	localparam int W = ratnorm_pkg::VALUE_WIDTH;
	localparam int M = ratnorm_pkg::MAG_WIDTH;

	ratnorm_pkg::pc_t        pc_q;
	ratnorm_pkg::ctrl_word_t cw;
	logic                    jump;
	logic                    in_accept;
	logic                    out_busy;

	logic [M-1:0]                        n_mag_q, d_mag_q;
	logic                                neg_q;
	logic [M-1:0]                        a_q, b_q;
	logic [ratnorm_pkg::CNT_WIDTH-1:0]   shift_q;
	logic [M-1:0]                        divisor_q, rem_q, quo_q, rn_q;
	logic [ratnorm_pkg::CNT_WIDTH-1:0]   cnt_q;

	logic                                out_valid_q;
	logic [W-1:0]                        out_num_q;
	logic [ratnorm_pkg::DEN_WIDTH-1:0]   out_den_q;
	logic                                out_flag_q;

	logic [W-1:0] in_num, in_den;
	logic [M-1:0] in_num_mag, in_den_mag;
	logic         a_gt_b;
	logic [M:0]   trial;
	logic         q_bit;
	logic [M-1:0] rem_next;
	logic [M-1:0] rn_sat, rd_sat;

	// Input unpacking and magnitudes; the most negative value keeps its true magnitude.
	assign in_num     = s_axis_tdata[W-1:0];
	assign in_den     = s_axis_tdata[2*W-1:W];
	assign in_num_mag = in_num[W-1] ? M'(-in_num) : M'(in_num);
	assign in_den_mag = in_den[W-1] ? M'(-in_den) : M'(in_den);

	// Handshake.
	assign s_axis_tready = (pc_q == ratnorm_pkg::PC_WAIT);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_busy      = out_valid_q && !m_axis_tready;

	// Compare for the gcd and trial subtract for the divider.
	assign a_gt_b   = (a_q > b_q);
	assign trial    = {rem_q, quo_q[M-1]} - {1'b0, divisor_q};
	assign q_bit    = !trial[M];
	assign rem_next = q_bit ? trial[M-1:0] : {rem_q[M-2:0], quo_q[M-1]};

	// Saturate reduced magnitudes to the signed range.
	assign rn_sat = (rn_q  > ratnorm_pkg::MAG_MAX) ? ratnorm_pkg::MAG_MAX : rn_q;
	assign rd_sat = (quo_q > ratnorm_pkg::MAG_MAX) ? ratnorm_pkg::MAG_MAX : quo_q;

	// Control store fetch and jump condition.
	always_comb begin
		cw = ratnorm_pkg::ctrl_rom(pc_q);
		unique case (cw.cond)
			ratnorm_pkg::C_NEVER:     jump = 1'b0;
			ratnorm_pkg::C_ALWAYS:    jump = 1'b1;
			ratnorm_pkg::C_NO_ACCEPT: jump = !in_accept;
			ratnorm_pkg::C_ANY_ZERO:  jump = (n_mag_q == '0) || (d_mag_q == '0);
			ratnorm_pkg::C_BOTH_EVEN: jump = !a_q[0] && !b_q[0];
			ratnorm_pkg::C_A_EVEN:    jump = !a_q[0];
			ratnorm_pkg::C_B_EVEN:    jump = !b_q[0];
			ratnorm_pkg::C_A_NE_B:    jump = (a_q != b_q);
			ratnorm_pkg::C_CNT_NZ:    jump = (cnt_q != '0);
			ratnorm_pkg::C_OUT_BUSY:  jump = out_busy;
			default:                  jump = 1'b0;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ratnorm_pkg::PC_WAIT;
		end else if (jump) begin
			pc_q <= cw.target;
		end else begin
			pc_q <= pc_q + ratnorm_pkg::pc_t'(1);
		end
	end

	// Datapath driven by the current control word.
	always_ff @(posedge clk) begin
		case (cw.op)
			ratnorm_pkg::OP_LOAD: begin
				if (in_accept) begin
					n_mag_q <= in_num_mag;
					d_mag_q <= in_den_mag;
					neg_q   <= in_num[W-1] ^ in_den[W-1];
					a_q     <= in_num_mag;
					b_q     <= in_den_mag;
					shift_q <= '0;
				end
			end
			ratnorm_pkg::OP_HALVE_AB: begin
				if (!a_q[0] && !b_q[0]) begin
					a_q     <= a_q >> 1;
					b_q     <= b_q >> 1;
					shift_q <= shift_q + ratnorm_pkg::CNT_WIDTH'(1);
				end
			end
			ratnorm_pkg::OP_HALVE_A: begin
				if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end
			end
			ratnorm_pkg::OP_HALVE_B: begin
				if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end
			end
			ratnorm_pkg::OP_SUB: begin
				a_q <= a_gt_b ? b_q : a_q;
				b_q <= a_gt_b ? (a_q - b_q) : (b_q - a_q);
			end
			ratnorm_pkg::OP_SETUP_N: begin
				divisor_q <= a_q << shift_q;
				quo_q     <= n_mag_q;
				rem_q     <= '0;
				cnt_q     <= ratnorm_pkg::CNT_WIDTH'(M - 1);
			end
			ratnorm_pkg::OP_DIV: begin
				rem_q <= rem_next;
				quo_q <= {quo_q[M-2:0], q_bit};
				cnt_q <= cnt_q - ratnorm_pkg::CNT_WIDTH'(1);
			end
			ratnorm_pkg::OP_SETUP_D: begin
				rn_q  <= quo_q;
				quo_q <= d_mag_q;
				rem_q <= '0;
				cnt_q <= ratnorm_pkg::CNT_WIDTH'(M - 1);
			end
			default: begin
			end
		endcase
	end

	// Output register: loaded when empty or being emptied in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_busy && (cw.op == ratnorm_pkg::OP_OUT_FRAC ||
				cw.op == ratnorm_pkg::OP_OUT_ZERO)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_busy && cw.op == ratnorm_pkg::OP_OUT_FRAC) begin
			out_num_q  <= neg_q ? W'(-rn_sat) : W'(rn_sat);
			out_den_q  <= rd_sat[ratnorm_pkg::DEN_WIDTH-1:0];
			out_flag_q <= 1'b0;
		end else if (!out_busy && cw.op == ratnorm_pkg::OP_OUT_ZERO) begin
			out_num_q  <= '0;
			out_den_q  <= ratnorm_pkg::DEN_WIDTH'(1);
			out_flag_q <= (d_mag_q == '0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = ratnorm_pkg::OUT_TDATA_WIDTH'({out_den_q, out_num_q});
	assign m_axis_tuser  = out_flag_q;

endmodule

### hw/rtl/ratnorm_chk.sv
// Port-level checker for rational_normalize, bound to the top level.
// Depends on ratnorm_pkg for the field widths.

module ratnorm_chk (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_axis_tvalid,
	input logic                                   s_axis_tready,
	input logic                                   m_axis_tvalid,
	input logic                                   m_axis_tready,
	input logic [ratnorm_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
	input logic                                   m_axis_tuser
);

	localparam int W = ratnorm_pkg::VALUE_WIDTH;
	localparam int D = ratnorm_pkg::DEN_WIDTH;

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// Only one transaction is in flight: input closes after an acceptance.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while a transaction is in progress");

	// The reduced denominator is never zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[W+D-1:W] != '0)
		else $error("zero denominator on output");

	// A zero numerator or a flagged error always comes out as 0/1.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser || m_axis_tdata[W-1:0] == '0) |->
			m_axis_tdata[W-1:0] == '0 && m_axis_tdata[W+D-1:W] == D'(1))
		else $error("zero result not in the form 0/1");

endmodule

bind rational_normalize ratnorm_chk u_ratnorm_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### tb/sv/testbench.sv
// Self-checking testbench for rational_normalize, the stream-based fraction reducer.
// Depends on ratnorm_pkg and rational_normalize; predicts each reduced fraction on its own.

module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = ratnorm_pkg::VALUE_WIDTH;
	localparam int DEN_W = ratnorm_pkg::DEN_WIDTH;
	localparam int PAD_W = ratnorm_pkg::OUT_TDATA_WIDTH - W - DEN_W;

	// Edge values of a signed operand.
	localparam logic [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};

	// Receiver hold-off length and the cap on printed mismatches.
	localparam int LONG_HOLD_CYCLES = 800;
	localparam int MAX_REPORTS = 40;

	// One reduced fraction as it leaves the block.
	typedef struct packed {
		logic [W-1:0]     num;
		logic [DEN_W-1:0] den;
		logic             zero_den;
	} fraction_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	// numerator_in, denominator_in
	logic [ratnorm_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata = '0;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	// numerator_out, denominator_out, zero padding
	logic [ratnorm_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata;
	// zero_denominator
	logic                       m_axis_tuser;

	// Reduced fractions still owed by the block, oldest first.
	fraction_t reduced_q[$];

	int unsigned error_count = 0;
	int unsigned fractions_sent = 0;
	int unsigned fractions_checked = 0;
	int unsigned zero_den_seen = 0;

	// Sender and receiver pacing controls.
	bit tx_gaps = 1'b0;
	int unsigned tx_burst_left = 0;
	bit rx_stalls = 1'b0;
	bit hold_request = 1'b0;
	int unsigned hold_left = 0;
	bit rx_ready_phase = 1'b1;
	int unsigned rx_phase_left = 0;

	rational_normalize u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicts the fraction in lowest terms, with the sign on the numerator.
	function automatic fraction_t reduce_fraction(input logic [W-1:0] num_raw,
			input logic [W-1:0] den_raw);
		logic [W-1:0] num_mag, den_mag, a, b, rem, q_num, q_den;
		fraction_t res;
		begin
			// The most negative value keeps its true magnitude as an unsigned number.
			num_mag = num_raw[W-1] ? W'(-num_raw) : num_raw;
			den_mag = den_raw[W-1] ? W'(-den_raw) : den_raw;
			res.zero_den = 1'b0;
			res.num = '0;
			res.den = DEN_W'(1);
			if (den_mag == '0) begin
				res.zero_den = 1'b1;
				return res;
			end
			if (num_mag == '0)
				return res;
			// Euclid's algorithm on the magnitudes.
			a = num_mag;
			b = den_mag;
			while (b != '0) begin
				rem = a % b;
				a = b;
				b = rem;
			end
			q_num = num_mag / a;
			q_den = den_mag / a;
			// A quotient of the most negative value may not fit; it saturates.
			if (q_num > ratnorm_pkg::MAG_MAX)
				q_num = ratnorm_pkg::MAG_MAX;
			if (q_den > ratnorm_pkg::MAG_MAX)
				q_den = ratnorm_pkg::MAG_MAX;
			res.num = (num_raw[W-1] != den_raw[W-1]) ? W'(-q_num) : q_num;
			res.den = q_den[DEN_W-1:0];
			return res;
		end
	endfunction

	// Offers one fraction and waits for its transaction, pausing between bursts.
	task automatic send_fraction(input logic [W-1:0] num, input logic [W-1:0] den);
		begin
			if (tx_gaps && tx_burst_left == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				tx_burst_left = $urandom_range(1, 12);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= {den, num};
			@(posedge clk);
			while (!s_axis_tready)
				@(posedge clk);
			reduced_q.push_back(reduce_fraction(num, den));
			fractions_sent++;
			if (tx_burst_left != 0)
				tx_burst_left--;
		end
	endtask

	// Stops offering and waits until every owed result has come back.
	task automatic wait_for_results();
		begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while (reduced_q.size() != 0)
				@(posedge clk);
		end
	endtask

	function automatic logic [W-1:0] edge_operand(input int unsigned idx);
		begin
			case (idx)
				0: return '0;
				1: return W'(1);
				2: return VAL_MAX;
				3: return -VAL_MAX;
				4: return VAL_MIN;
				default: return VAL_MAX - W'(1);
			endcase
		end
	endfunction

	// Picks a random signed fraction, with a bias toward shared factors.
	task automatic pick_fraction(output logic [W-1:0] num, output logic [W-1:0] den);
		int unsigned sel, gbits, abits;
		logic [W-1:0] g, a, b;
		begin
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				// Both values share a random factor, so the reduction has real work.
				gbits = $urandom_range(0, W - 12);
				abits = W - 2 - gbits;
				g = W'(($urandom & ((64'd1 << gbits) - 1)) + 1);
				a = W'($urandom & ((64'd1 << abits) - 1)) >> $urandom_range(0, abits);
				b = W'($urandom & ((64'd1 << abits) - 1)) >> $urandom_range(0, abits);
				if (b == '0 && $urandom_range(0, 3) != 0)
					b = W'(1);
				num = a * g;
				den = b * g;
			end else if (sel < 70) begin
				num = W'({$urandom, $urandom});
				den = W'({$urandom, $urandom});
			end else if (sel < 80) begin
				num = W'($urandom_range(0, 40)) - W'(20);
				den = W'($urandom_range(0, 40)) - W'(20);
			end else if (sel < 90) begin
				num = W'(1) << $urandom_range(0, W - 1);
				den = W'(1) << $urandom_range(0, W - 1);
			end else if (sel < 95) begin
				num = edge_operand($urandom_range(0, 5));
				den = edge_operand($urandom_range(0, 5));
			end else begin
				num = W'({$urandom, $urandom});
				den = '0;
			end
			if ($urandom_range(0, 1))
				num = -num;
			if ($urandom_range(0, 1))
				den = -den;
		end
	endtask

	task automatic report_mismatch(input string field, input longint exp_v,
			input longint act_v);
		begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field,
					exp_v, act_v);
		end
	endtask

	// Output side: a random ready pattern, always-ready stretches, and a long hold-off.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (!rx_stalls) begin
			m_axis_tready <= 1'b1;
		end else begin
			if (rx_phase_left != 0) begin
				rx_phase_left--;
			end else begin
				rx_ready_phase = !rx_ready_phase;
				rx_phase_left = rx_ready_phase ? $urandom_range(0, 23) : $urandom_range(0, 7);
			end
			m_axis_tready <= rx_ready_phase;
		end
	end

	// Compares each output transaction with the oldest owed fraction.
	always @(posedge clk) begin
		fraction_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (reduced_q.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual %0d/%0d", $time,
						$signed(m_axis_tdata[W-1:0]), m_axis_tdata[W +: DEN_W]);
			end else begin
				want = reduced_q.pop_front();
				fractions_checked++;
				if (want.zero_den)
					zero_den_seen++;
				if (m_axis_tdata[W-1:0] !== want.num)
					report_mismatch("numerator_out", $signed(want.num),
						$signed(m_axis_tdata[W-1:0]));
				if (m_axis_tdata[W +: DEN_W] !== want.den)
					report_mismatch("denominator_out", want.den, m_axis_tdata[W +: DEN_W]);
				if (m_axis_tuser !== want.zero_den)
					report_mismatch("zero_denominator", want.zero_den, m_axis_tuser);
				if (m_axis_tdata[ratnorm_pkg::OUT_TDATA_WIDTH-1 -: PAD_W] !== '0)
					report_mismatch("tdata padding", 0,
						m_axis_tdata[ratnorm_pkg::OUT_TDATA_WIDTH-1 -: PAD_W]);
			end
		end
	end

	// Edge operands, sign combinations and each special case.
	task automatic test_directed_cases();
		begin
			tx_gaps = 1'b0;
			rx_stalls = 1'b0;
			send_fraction('0, W'(5));
			send_fraction('0, -W'(7));
			send_fraction(W'(9), '0);
			send_fraction('0, '0);
			send_fraction(VAL_MIN, '0);
			send_fraction(W'(6), W'(4));
			send_fraction(-W'(6), W'(4));
			send_fraction(W'(6), -W'(4));
			send_fraction(-W'(6), -W'(4));
			send_fraction(VAL_MAX, VAL_MAX);
			send_fraction(VAL_MAX, -VAL_MAX);
			send_fraction(VAL_MAX, W'(1));
			send_fraction(W'(1), -VAL_MAX);
			// The most negative value, whose magnitude may need saturation.
			send_fraction(VAL_MIN, W'(1));
			send_fraction(VAL_MIN, -W'(1));
			send_fraction(VAL_MIN, VAL_MIN);
			send_fraction(W'(3), VAL_MIN);
			send_fraction(VAL_MIN, W'(6));
			send_fraction(W'(1) << (W - 2), W'(1) << (W - 3));
			send_fraction(-W'(1), -W'(1));
			send_fraction(W'(1071), W'(462));
			send_fraction(W'(7), W'(13));
			send_fraction(-VAL_MAX, W'(2));
			send_fraction(VAL_MAX - W'(1), VAL_MAX >> 1);
			wait_for_results();
		end
	endtask

	// Zero numerators and zero denominators mixed with ordinary fractions.
	task automatic test_zero_operands();
		logic [W-1:0] num, den;
		begin
			tx_gaps = 1'b1;
			rx_stalls = 1'b1;
			repeat (60) begin
				pick_fraction(num, den);
				case ($urandom_range(0, 2))
					0: den = '0;
					1: num = '0;
					default: ;
				endcase
				send_fraction(num, den);
			end
			wait_for_results();
		end
	endtask

	// Bulk random fractions with bursty input and a stalling output.
	task automatic test_mixed_random();
		logic [W-1:0] num, den;
		begin
			tx_gaps = 1'b1;
			rx_stalls = 1'b1;
			repeat (1300) begin
				pick_fraction(num, den);
				send_fraction(num, den);
			end
			wait_for_results();
		end
	endtask

	// The output holds off long enough that the block fills and stalls its input.
	task automatic test_output_hold();
		logic [W-1:0] num, den;
		begin
			tx_gaps = 1'b0;
			rx_stalls = 1'b0;
			hold_request = 1'b1;
			@(posedge clk);
			repeat (12) begin
				pick_fraction(num, den);
				send_fraction(num, den);
			end
			wait_for_results();
		end
	endtask

	// Back-to-back transactions with no idling on either side.
	task automatic test_back_to_back();
		logic [W-1:0] num, den;
		begin
			tx_gaps = 1'b0;
			rx_stalls = 1'b0;
			repeat (200) begin
				pick_fraction(num, den);
				send_fraction(num, den);
			end
			wait_for_results();
		end
	endtask

	// Bursty input against an output that is always ready.
	task automatic test_bursty_input();
		logic [W-1:0] num, den;
		begin
			tx_gaps = 1'b1;
			rx_stalls = 1'b0;
			repeat (150) begin
				pick_fraction(num, den);
				send_fraction(num, den);
			end
			wait_for_results();
		end
	endtask

	// Main sequence: reset once, run each test, then report.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_zero_operands();
		test_mixed_random();
		test_output_hold();
		test_back_to_back();
		test_bursty_input();
		// Leave room for any stray result after the last one.
		repeat (300) @(posedge clk);
		$display("Reduced %0d fractions, %0d checked, %0d with a zero denominator,",
			fractions_sent, fractions_checked, zero_den_seen);
		$display("under bursty input, random and long output stalls, and no-idle runs.");
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(40_000_000);
		$display("Timeout with %0d results still owed.", reduced_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
